FILE: hw/rtl/mesh_vertex_project_and_face_cull_top_assert.svh
// Assertion macros used by the checker file of the projection block.
`ifndef MESH_VERTEX_PROJECT_AND_FACE_CULL_TOP_ASSERT_SVH
`define MESH_VERTEX_PROJECT_AND_FACE_CULL_TOP_ASSERT_SVH
// Implication checked on every clock edge while out of reset.
`define MVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked while out of reset.
`define MVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/mvp_pkg.sv
// Package with types and constants of the vertex projection block.
package mvp_pkg;

  localparam int unsigned ModeW  = 2;

  // Draw mode codes.
  localparam logic [ModeW-1:0] ModeSkip  = 2'd0;
  localparam logic [ModeW-1:0] ModeBack  = 2'd1;
  localparam logic [ModeW-1:0] ModeFront = 2'd2;

  // Command codes.
  localparam logic CmdVertex = 1'b0;
  localparam logic CmdFace   = 1'b1;

  // Register indexes.
  localparam logic [2:0] RegSinX  = 3'd0;
  localparam logic [2:0] RegCosX  = 3'd1;
  localparam logic [2:0] RegSinY  = 3'd2;
  localparam logic [2:0] RegCosY  = 3'd3;
  localparam logic [2:0] RegZoom  = 3'd4;
  localparam logic [2:0] RegDist  = 3'd5;
  localparam logic [2:0] RegCull  = 3'd6;
  localparam logic [2:0] RegCentY = 3'd7;

  // Divider control passed to the shared divider.
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [16:0] den;
  } div_req_t;

endpackage

FILE: hw/rtl/mvp_ram.sv
// Generic single-port RAM with registered read.
module mvp_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One access per cycle: an optional write, and a read that returns the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

FILE: hw/rtl/mvp_div.sv
// Radix-2 restoring divider, signed, truncating, one quotient bit per cycle.
module mvp_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mvp_pkg::div_req_t req_i,
  output logic              busy_o,
  output logic [15:0]       quot_o
);

  logic [31:0] rem_q, rem_d, mag_q, mag_d;
  logic [16:0] dmag_q, dmag_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        neg_q, neg_d, busy_q, busy_d;
  logic [32:0] trial;
  logic [31:0] nabs;

  always_comb begin
    nabs = req_i.num[31] ? 32'(-req_i.num) : 32'(req_i.num);
    trial = {rem_q, mag_q[31]} - {16'd0, dmag_q};
  end

  // Shift in one numerator bit each cycle while busy; quotient collects in mag.
  always_comb begin
    rem_d = rem_q; mag_d = mag_q; dmag_d = dmag_q;
    cnt_d = cnt_q; neg_d = neg_q; busy_d = busy_q;
    if (req_i.start) begin
      rem_d  = '0;
      mag_d  = nabs;
      dmag_d = req_i.den[16] ? 17'(-req_i.den) : 17'(req_i.den);
      neg_d  = req_i.num[31] ^ req_i.den[16];
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        mag_d = {mag_q[30:0], 1'b1};
      end else begin
        rem_d = {rem_q[30:0], mag_q[31]};
        mag_d = {mag_q[30:0], 1'b0};
      end
      cnt_d  = cnt_q - 6'd1;
      busy_d = (cnt_q != 6'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    mag_q  <= mag_d;
    dmag_q <= dmag_d;
    neg_q  <= neg_d;
  end

  assign busy_o = busy_q;
  assign quot_o = neg_q ? 16'(-mag_q[15:0]) : mag_q[15:0];

endmodule

FILE: hw/rtl/mesh_vertex_project_and_face_cull_top.sv
// Top level: rotation, perspective projection and face classification.
// A vertex beat keeps the block busy through 12 multiply steps on one shared
// 17x17 multiplier, two runs of the serial divider and one RAM write.
// A face beat passes five RAM read steps and two multiply steps, then the mode
// and output states, before its result shows.
// Result register frees the input side once the result is taken.
// Asynchronous active-low reset loads register defaults; the vertex RAM is not
// cleared, and unwritten entries read as undefined.
module mesh_vertex_project_and_face_cull_top #(
  parameter int unsigned VERTEX_DEPTH   = 256,
  parameter int unsigned TRIG_FRAC_BITS = 8,
  parameter int unsigned CENTER_X       = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [7:0]  vertex_index_i,
  input  logic signed [15:0] model_x_i,
  input  logic signed [15:0] model_y_i,
  input  logic signed [15:0] model_z_i,
  input  logic [7:0]  corner_a_i,
  input  logic [7:0]  corner_b_i,
  input  logic [7:0]  corner_c_i,
  input  logic [7:0]  corner_d_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [15:0] screen_ax_o,
  output logic signed [15:0] screen_ay_o,
  output logic signed [15:0] screen_bx_o,
  output logic signed [15:0] screen_by_o,
  output logic signed [15:0] screen_cx_o,
  output logic signed [15:0] screen_cy_o,
  output logic signed [15:0] screen_dx_o,
  output logic signed [15:0] screen_dy_o,
  output logic [1:0]  draw_mode_o
);

  localparam int unsigned AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  // One bit above the index or address so that the depth itself fits.
  localparam int unsigned IdxW = ((AW > 8) ? AW : 8) + 1;

  // Sequencer states.
  typedef enum logic [9:0] {
    StIdle  = 10'b0000000001,
    StMul   = 10'b0000000010,
    StDivX  = 10'b0000000100,
    StDivY  = 10'b0000001000,
    StWrite = 10'b0000010000,
    StRead  = 10'b0000100000,
    StCross = 10'b0001000000,
    StMode  = 10'b0010000000,
    StOut   = 10'b0100000000,
    StWait  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [15:0] sinx_q, cosx_q, siny_q, cosy_q, dist_q, centy_q;
  logic [14:0] zoom_q;
  logic        cull_q;
  logic        wr_en;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sinx_q  <= 16'sd0;
      cosx_q  <= 16'sd256;
      siny_q  <= 16'sd0;
      cosy_q  <= 16'sd256;
      zoom_q  <= 15'd256;
      dist_q  <= 16'sd512;
      cull_q  <= 1'b0;
      centy_q <= 16'sd100;
    end else if (wr_en) begin
      case (reg_idx)
        mvp_pkg::RegSinX:  sinx_q  <= pwdata[15:0];
        mvp_pkg::RegCosX:  cosx_q  <= pwdata[15:0];
        mvp_pkg::RegSinY:  siny_q  <= pwdata[15:0];
        mvp_pkg::RegCosY:  cosy_q  <= pwdata[15:0];
        mvp_pkg::RegZoom:  zoom_q  <= pwdata[14:0];
        mvp_pkg::RegDist:  dist_q  <= pwdata[15:0];
        mvp_pkg::RegCull:  cull_q  <= pwdata[0];
        mvp_pkg::RegCentY: centy_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      mvp_pkg::RegSinX:  prdata = 32'(sinx_q);
      mvp_pkg::RegCosX:  prdata = 32'(cosx_q);
      mvp_pkg::RegSinY:  prdata = 32'(siny_q);
      mvp_pkg::RegCosY:  prdata = 32'(cosy_q);
      mvp_pkg::RegZoom:  prdata = {17'd0, zoom_q};
      mvp_pkg::RegDist:  prdata = 32'(dist_q);
      mvp_pkg::RegCull:  prdata = {31'd0, cull_q};
      mvp_pkg::RegCentY: prdata = 32'(centy_q);
      default:           prdata = '0;
    endcase
  end

  // Captured input beat.
  logic [7:0]  vidx_q;
  logic signed [15:0] mx_q, my_q, mz_q;
  logic [7:0]  crn_q [4];

  // Shared multiplier and accumulator, step counter.
  logic [3:0]  step_q, step_d;
  logic signed [16:0] ma, mb;
  logic signed [33:0] prod;
  logic signed [47:0] acc_q, acc_d;
  logic signed [15:0] cs_q, ss_q, cc_q, sc_q, rx_q, ry_q;
  logic signed [15:0] px_q, py_q;
  logic signed [15:0] shf;

  assign prod = ma * mb;
  // Arithmetic shift by the fraction width, wrapped to 16 bits.
  assign shf  = 16'(acc_d >>> TRIG_FRAC_BITS);

  // Divider.
  mvp_pkg::div_req_t dreq;
  logic        dbusy;
  logic [15:0] dquot;
  logic signed [16:0] den_q;

  mvp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .busy_o (dbusy),
    .quot_o (dquot)
  );

  // Vertex RAM.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [31:0]   ram_wdata, ram_rdata;

  mvp_ram #(.Width(32), .Depth(VERTEX_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Face corner registers, out-of-range flags and result.
  logic [15:0] xs_q [4];
  logic [15:0] ys_q [4];
  logic [3:0]  oor_q;
  logic [15:0] cross_q;
  logic [1:0]  mode_q;
  logic        ovld_q;
  logic        in_acc;
  logic [15:0] fx, fy;
  logic [IdxW-1:0] cidx;

  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;

  // Multiplier operand select by step.
  always_comb begin
    ma = '0; mb = '0; acc_d = acc_q;
    case (step_q)
      4'd0: begin ma = 17'(cosx_q); mb = 17'(siny_q); acc_d = 48'(prod); end
      4'd1: begin ma = 17'(siny_q); mb = 17'(sinx_q); acc_d = 48'(prod); end
      4'd2: begin ma = 17'(cosx_q); mb = 17'(cosy_q); acc_d = 48'(prod); end
      4'd3: begin ma = 17'(sinx_q); mb = 17'(cosy_q); acc_d = 48'(prod); end
      4'd4: begin ma = 17'(mx_q); mb = 17'(sinx_q); acc_d = 48'(prod); end
      4'd5: begin ma = 17'(my_q); mb = 17'(cosx_q); acc_d = acc_q + 48'(prod); end
      4'd6: begin ma = 17'(mx_q); mb = 17'(cs_q); acc_d = 48'(prod); end
      4'd7: begin ma = 17'(my_q); mb = 17'(ss_q); acc_d = acc_q - 48'(prod); end
      4'd8: begin ma = 17'(mz_q); mb = 17'(cosy_q); acc_d = acc_q + 48'(prod); end
      4'd9: begin ma = 17'(mx_q); mb = 17'(cc_q); acc_d = 48'(prod); end
      4'd10: begin ma = 17'(my_q); mb = 17'(sc_q); acc_d = acc_q - 48'(prod); end
      4'd11: begin ma = 17'(mz_q); mb = 17'(siny_q); acc_d = acc_q - 48'(prod); end
      // Face cross product terms, 16-bit wrapped operands.
      4'd12: begin
        ma = 17'(signed'(16'(xs_q[2] - xs_q[0])));
        mb = 17'(signed'(16'(ys_q[1] - ys_q[0])));
        acc_d = 48'(prod);
      end
      4'd13: begin
        ma = 17'(signed'(16'(xs_q[1] - xs_q[0])));
        mb = 17'(signed'(16'(ys_q[2] - ys_q[0])));
        acc_d = acc_q - 48'(prod);
      end
      default: ;
    endcase
  end

  // Corner address for the current read step.
  always_comb begin
    cidx = IdxW'(crn_q[step_q[1:0]]);
    fx   = 16'(ram_rdata[15:0] + 16'(CENTER_X));
    fy   = 16'(ram_rdata[31:16] + centy_q);
  end

  // Sequencer.
  always_comb begin
    state_d = state_q; step_d = step_q;
    dreq = '0; ram_we = 1'b0;
    ram_addr = AW'(cidx);
    ram_wdata = {py_q, px_q};
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (cmd_i == mvp_pkg::CmdVertex) begin
            state_d = StMul; step_d = 4'd0;
          end else begin
            state_d = StRead; step_d = 4'd0;
          end
        end
      end
      StMul: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd11) begin
          state_d = StDivX;
          dreq.start = 1'b1;
          dreq.num = 32'(rx_q) * 32'(signed'({1'b0, zoom_q}));
          dreq.den = 17'(shf) + 17'(dist_q);
        end
      end
      StDivX: begin
        if (!dbusy) begin
          state_d = StDivY;
          dreq.start = 1'b1;
          dreq.num = 32'(ry_q) * 32'(signed'({1'b0, zoom_q}));
          dreq.den = den_q;
        end
      end
      StDivY: begin
        if (!dbusy && !dreq.start) state_d = StWrite;
      end
      StWrite: begin
        ram_addr = AW'(vidx_q);
        ram_we = (IdxW'(vidx_q) < IdxW'(VERTEX_DEPTH)) ? 1'b1 : 1'b0;
        state_d = StIdle;
      end
      StRead: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd4) begin
          state_d = StCross; step_d = 4'd12;
        end
      end
      StCross: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd13) state_d = StMode;
      end
      StMode:  state_d = StOut;
      StOut:   state_d = StWait;
      StWait:  if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      if (state_q == StOut) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (in_acc) begin
      vidx_q <= vertex_index_i;
      mx_q <= model_x_i; my_q <= model_y_i; mz_q <= model_z_i;
      crn_q[0] <= corner_a_i; crn_q[1] <= corner_b_i;
      crn_q[2] <= corner_c_i; crn_q[3] <= corner_d_i;
    end
    if (state_q == StMul) begin
      case (step_q)
        4'd0:  cs_q <= shf;
        4'd1:  ss_q <= shf;
        4'd2:  cc_q <= shf;
        4'd3:  sc_q <= shf;
        4'd5:  rx_q <= shf;
        4'd8:  ry_q <= shf;
        4'd11: den_q <= 17'(shf) + 17'(dist_q);
        default: ;
      endcase
    end
    if (state_q == StDivX && !dbusy) px_q <= (den_q == '0) ? 16'd0 : dquot;
    if (state_q == StDivY && !dbusy) py_q <= (den_q == '0) ? 16'd0 : dquot;
    // RAM read data is registered, so it arrives in the cycle after the address.
    if (state_q == StRead) begin
      oor_q[step_q[1:0]] <= (IdxW'(crn_q[step_q[1:0]]) >= IdxW'(VERTEX_DEPTH));
      if (step_q != 4'd0) begin
        xs_q[step_q[1:0] - 2'd1] <= oor_q[step_q[1:0] - 2'd1] ?
                                    16'(CENTER_X) : fx;
        ys_q[step_q[1:0] - 2'd1] <= oor_q[step_q[1:0] - 2'd1] ? centy_q : fy;
      end
    end
    if (state_q == StCross && step_q == 4'd13) cross_q <= 16'(acc_d);
    if (state_q == StMode) begin
      if ($signed(cross_q) > 16'sd0)  mode_q <= mvp_pkg::ModeFront;
      else if (cull_q)                mode_q <= mvp_pkg::ModeSkip;
      else                            mode_q <= mvp_pkg::ModeBack;
    end
  end

  assign out_valid_o = ovld_q;
  assign screen_ax_o = xs_q[0];
  assign screen_ay_o = ys_q[0];
  assign screen_bx_o = xs_q[1];
  assign screen_by_o = ys_q[1];
  assign screen_cx_o = xs_q[2];
  assign screen_cy_o = ys_q[2];
  assign screen_dx_o = xs_q[3];
  assign screen_dy_o = ys_q[3];
  assign draw_mode_o = mode_q;

endmodule

FILE: hw/rtl/mvp_checker.sv
// Port-level checker for the projection block and its bind.
`include "mesh_vertex_project_and_face_cull_top_assert.svh"
module mvp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       cmd_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] draw_mode_o
);

  // Draw mode never carries the unused code.
  `MVP_ASSERT_IMP(a_mode_ok, clk_i, rst_ni, out_valid_o, draw_mode_o != 2'd3)
  // A result never sits beside a ready input side.
  `MVP_ASSERT_IMP(a_busy_out, clk_i, rst_ni, out_valid_o, !in_ready_o)
  // An accepted beat drops ready on the next cycle.
  `MVP_ASSERT_NXT(a_acc_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // A vertex beat brings no result right after acceptance.
  `MVP_ASSERT_NXT(a_vtx_quiet, clk_i, rst_ni,
    in_valid_i && in_ready_o && !cmd_i, !out_valid_o)

endmodule

bind mesh_vertex_project_and_face_cull_top mvp_checker u_mvp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .draw_mode_o (draw_mode_o)
);

FILE: bench/mesh_vertex_project_and_face_cull_checker.sv
// Checker that predicts and compares the face results of the projection block.
`timescale 1ns / 100ps

module mesh_vertex_project_and_face_cull_checker #(
  parameter int unsigned VERTEX_DEPTH   = 256,
  parameter int unsigned TRIG_FRAC_BITS = 8,
  parameter int unsigned CENTER_X       = 160
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        cmd_i,
  input  logic [7:0]  vertex_index_i,
  input  logic [15:0] model_x_i,
  input  logic [15:0] model_y_i,
  input  logic [15:0] model_z_i,
  input  logic [7:0]  corner_a_i,
  input  logic [7:0]  corner_b_i,
  input  logic [7:0]  corner_c_i,
  input  logic [7:0]  corner_d_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [15:0] screen_ax_i,
  input  logic [15:0] screen_ay_i,
  input  logic [15:0] screen_bx_i,
  input  logic [15:0] screen_by_i,
  input  logic [15:0] screen_cx_i,
  input  logic [15:0] screen_cy_i,
  input  logic [15:0] screen_dx_i,
  input  logic [15:0] screen_dy_i,
  input  logic [1:0]  draw_mode_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] ax, ay, bx, by, cx, cy, dx, dy;
    logic [1:0]  mode;
  } face_beat_t;

  // Shadow of the configuration registers.
  int sin_x, cos_x, sin_y, cos_y, zoom, view_dist, cull, centre_y;
  logic [31:0] screen_store [VERTEX_DEPTH];
  face_beat_t  face_queue [$];

  assign pending_o = face_queue.size();

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors_o++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", what, got, want));
  endtask

  // Arithmetic shift by the fraction width, wrapped to 16 bits.
  function automatic int frac_shift(input longint v);
    logic signed [15:0] r;
    r = 16'(v >>> TRIG_FRAC_BITS);
    return int'(r);
  endfunction

  function automatic logic [15:0] perspective(input int c, input int den);
    longint num;
    num = longint'(c) * longint'(zoom);
    if (den == 0) return 16'd0;
    return 16'(num / longint'(den));
  endfunction

  // Rotate, project and pack the screen position of one vertex.
  function automatic logic [31:0] project_vertex(input logic [15:0] xi, yi, zi);
    longint x, y, z;
    int cs, ss, cc, sc, rx, ry, rz;
    x = longint'($signed(xi));
    y = longint'($signed(yi));
    z = longint'($signed(zi));
    cs = frac_shift(longint'(cos_x) * sin_y);
    ss = frac_shift(longint'(sin_y) * sin_x);
    cc = frac_shift(longint'(cos_x) * cos_y);
    sc = frac_shift(longint'(sin_x) * cos_y);
    rx = frac_shift(x * sin_x + y * cos_x);
    ry = frac_shift(x * cs - y * ss + z * cos_y);
    rz = frac_shift(x * cc - y * sc - z * sin_y);
    return {perspective(ry, rz + view_dist), perspective(rx, rz + view_dist)};
  endfunction

  function automatic face_beat_t classify_face(input logic [7:0] ia, ib, ic, id);
    logic [15:0] xs [4];
    logic [15:0] ys [4];
    logic [7:0]  idx [4];
    logic [31:0] e;
    logic signed [15:0] cross_term;
    face_beat_t r;
    idx = '{ia, ib, ic, id};
    for (int k = 0; k < 4; k++) begin
      e = (idx[k] < VERTEX_DEPTH) ? screen_store[idx[k]] : 32'd0;
      xs[k] = e[15:0] + 16'(CENTER_X);
      ys[k] = e[31:16] + 16'(centre_y);
    end
    cross_term = (xs[2] - xs[0]) * (ys[1] - ys[0]) - (xs[1] - xs[0]) * (ys[2] - ys[0]);
    r = '{xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3], mvp_pkg::ModeBack};
    if (cross_term > 0) r.mode = mvp_pkg::ModeFront;
    else if (cull != 0) r.mode = mvp_pkg::ModeSkip;
    return r;
  endfunction

  // Track register writes, accepted input beats and accepted result beats.
  always @(posedge clk_i or negedge rst_ni) begin
    face_beat_t want;
    if (!rst_ni) begin
      sin_x = 0; cos_x = 256; sin_y = 0; cos_y = 256;
      zoom = 256; view_dist = 512; cull = 0; centre_y = 100;
      face_queue.delete();
      errors_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[4:2])
          mvp_pkg::RegSinX:  sin_x = int'($signed(pwdata_i[15:0]));
          mvp_pkg::RegCosX:  cos_x = int'($signed(pwdata_i[15:0]));
          mvp_pkg::RegSinY:  sin_y = int'($signed(pwdata_i[15:0]));
          mvp_pkg::RegCosY:  cos_y = int'($signed(pwdata_i[15:0]));
          mvp_pkg::RegZoom:  zoom = int'(pwdata_i[14:0]);
          mvp_pkg::RegDist:  view_dist = int'($signed(pwdata_i[15:0]));
          mvp_pkg::RegCull:  cull = int'(pwdata_i[0]);
          mvp_pkg::RegCentY: centre_y = int'($signed(pwdata_i[15:0]));
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_i == mvp_pkg::CmdVertex) begin
          if (vertex_index_i < VERTEX_DEPTH)
            screen_store[vertex_index_i] = project_vertex(model_x_i, model_y_i, model_z_i);
        end else begin
          face_queue.push_back(classify_face(corner_a_i, corner_b_i, corner_c_i,
                                             corner_d_i));
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (face_queue.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          want = face_queue.pop_front();
          check_field("screen_ax", screen_ax_i, want.ax);
          check_field("screen_ay", screen_ay_i, want.ay);
          check_field("screen_bx", screen_bx_i, want.bx);
          check_field("screen_by", screen_by_i, want.by);
          check_field("screen_cx", screen_cx_i, want.cx);
          check_field("screen_cy", screen_cy_i, want.cy);
          check_field("screen_dx", screen_dx_i, want.dx);
          check_field("screen_dy", screen_dy_i, want.dy);
          check_field("draw_mode", 16'(draw_mode_i), 16'(want.mode));
        end
      end
    end
  end

endmodule

FILE: bench/tb_mesh_vertex_project_and_face_cull_top.sv
// Testbench top: stimulus, register setup and verdict for the projection block.
`timescale 1ns / 100ps

module tb_mesh_vertex_project_and_face_cull_top;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 200;
  localparam int HoldCycles = 500;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o;
  logic cmd_i = 1'b0;
  logic [7:0] vertex_index_i = '0;
  logic signed [15:0] model_x_i = '0, model_y_i = '0, model_z_i = '0;
  logic [7:0] corner_a_i = '0, corner_b_i = '0, corner_c_i = '0, corner_d_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic signed [15:0] screen_ax_o, screen_ay_o, screen_bx_o, screen_by_o;
  logic signed [15:0] screen_cx_o, screen_cy_o, screen_dx_o, screen_dy_o;
  logic [1:0] draw_mode_o;

  int errors, pending;
  int tx_idle_pct = 0, rx_idle_pct = 0;
  logic hold_req = 1'b0, hold_done = 1'b0;
  logic written [256];
  int stall_count = 0;

  always #5 clk_i = ~clk_i;

  mesh_vertex_project_and_face_cull_top DUT (.*);

  mesh_vertex_project_and_face_cull_checker checker_inst (
    .clk_i, .rst_ni, .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite),
    .paddr_i(paddr), .pwdata_i(pwdata), .pready_i(pready),
    .in_valid_i, .in_ready_i(in_ready_o), .cmd_i, .vertex_index_i,
    .model_x_i, .model_y_i, .model_z_i, .corner_a_i, .corner_b_i,
    .corner_c_i, .corner_d_i, .out_valid_i(out_valid_o), .out_ready_i,
    .screen_ax_i(screen_ax_o), .screen_ay_i(screen_ay_o),
    .screen_bx_i(screen_bx_o), .screen_by_i(screen_by_o),
    .screen_cx_i(screen_cx_o), .screen_cy_i(screen_cy_o),
    .screen_dx_i(screen_dx_o), .screen_dy_i(screen_dy_o),
    .draw_mode_i(draw_mode_o), .errors_o(errors), .pending_o(pending)
  );

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_done <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on cycles without any accepted beat or register access.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel)
      stall_count <= 0;
    else if (stall_count >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end else
      stall_count <= stall_count + 1;
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Present one input beat and hold it until the block takes it.
  task automatic send_beat(input logic cmd, input logic [7:0] idx,
                           input logic [15:0] x, y, z, input logic [7:0] a, b, c, d);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i <= cmd; vertex_index_i <= idx;
    model_x_i <= x; model_y_i <= y; model_z_i <= z;
    corner_a_i <= a; corner_b_i <= b; corner_c_i <= c; corner_d_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == mvp_pkg::CmdVertex) written[idx] = 1'b1;
  endtask

  task automatic put_vertex(input logic [7:0] idx, input logic [15:0] x, y, z);
    send_beat(mvp_pkg::CmdVertex, idx, x, y, z, 8'($urandom), 8'($urandom),
              8'($urandom), 8'($urandom));
  endtask

  task automatic put_face(input logic [7:0] a, b, c, d);
    send_beat(mvp_pkg::CmdFace, 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), a, b, c, d);
  endtask

  function automatic logic [7:0] pick_written();
    logic [7:0] k;
    do k = 8'($urandom); while (!written[k]);
    return k;
  endfunction

  // Wait until the block is idle: results drained and vertex work finished.
  task automatic settle();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic random_trig(output logic [31:0] s, output logic [31:0] c);
    int r;
    r = $urandom_range(3);
    if (r == 0) begin
      s = 32'($urandom);
      c = 32'($urandom);
    end else begin
      s = 32'($signed($urandom_range(512)) - 256);
      c = 32'($signed($urandom_range(512)) - 256);
    end
  endtask

  task automatic random_setup();
    logic [31:0] s, c;
    random_trig(s, c);
    reg_write(mvp_pkg::RegSinX, s); reg_write(mvp_pkg::RegCosX, c);
    random_trig(s, c);
    reg_write(mvp_pkg::RegSinY, s); reg_write(mvp_pkg::RegCosY, c);
    reg_write(mvp_pkg::RegZoom, ($urandom_range(3) == 0) ? 32'($urandom) :
              32'($urandom_range(512)));
    reg_write(mvp_pkg::RegDist, ($urandom_range(1) == 0) ? 32'($urandom) :
              32'($urandom_range(2000)));
    reg_write(mvp_pkg::RegCull, 32'($urandom_range(1)));
    reg_write(mvp_pkg::RegCentY, 32'($urandom));
  endtask

  initial begin
    for (int k = 0; k < 256; k++) written[k] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at reset settings: extremes, zero divisor, both windings.
    put_vertex(8'd0, 16'sd0, 16'sd0, 16'sd0);
    put_vertex(8'd255, 16'h7fff, 16'h7fff, 16'h7fff);
    put_vertex(8'd1, 16'h8000, 16'h8000, 16'h8000);
    put_vertex(8'd2, -16'sd512, 16'sd0, 16'sd0);
    put_vertex(8'd3, 16'sd100, 16'sd0, 16'sd0);
    put_vertex(8'd4, 16'sd0, 16'sd100, 16'sd0);
    put_vertex(8'd5, -16'sd100, 16'sd50, 16'sd7);
    put_face(8'd0, 8'd3, 8'd4, 8'd5);
    put_face(8'd0, 8'd4, 8'd3, 8'd5);
    put_face(8'd255, 8'd1, 8'd2, 8'd0);
    put_face(8'd2, 8'd2, 8'd2, 8'd2);
    settle();

    // Extreme register values, culling on.
    reg_write(mvp_pkg::RegSinX, 32'h8000); reg_write(mvp_pkg::RegCosX, 32'h7fff);
    reg_write(mvp_pkg::RegSinY, 32'h7fff); reg_write(mvp_pkg::RegCosY, 32'h8000);
    reg_write(mvp_pkg::RegZoom, 32'h7fff); reg_write(mvp_pkg::RegDist, 32'h8000);
    reg_write(mvp_pkg::RegCull, 32'd1); reg_write(mvp_pkg::RegCentY, 32'h7fff);
    put_vertex(8'd6, 16'h7fff, 16'h8000, 16'h7fff);
    put_vertex(8'd7, 16'h8000, 16'h7fff, 16'h0001);
    put_face(8'd3, 8'd4, 8'd5, 8'd6);
    put_face(8'd3, 8'd5, 8'd4, 8'd7);
    put_face(8'd6, 8'd7, 8'd255, 8'd1);
    settle();
    reg_write(mvp_pkg::RegZoom, 32'd0); reg_write(mvp_pkg::RegCentY, 32'h8000);
    put_face(8'd3, 8'd4, 8'd5, 8'd6);
    put_vertex(8'd8, 16'sd300, -16'sd20, 16'sd9);
    put_face(8'd8, 8'd3, 8'd0, 8'd1);
    settle();

    // Random phases: sender-light, receiver-light, then no idling.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin tx_idle_pct = 15; rx_idle_pct = 76; end
        1: begin tx_idle_pct = 76; rx_idle_pct = 15; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      random_setup();
      for (int n = 0; n < 215; n++) begin
        if (phase == 2 && n == 100) hold_req = 1'b1;
        if ($urandom_range(99) < 35)
          put_vertex(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        else
          put_face(pick_written(), pick_written(), pick_written(), pick_written());
        // Now and then wait for every result before going on.
        if ($urandom_range(99) == 0) begin
          in_valid_i <= 1'b0;
          wait (pending == 0);
          @(posedge clk_i);
        end
      end
      settle();
    end

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
